// ===== src/woct_pkg.sv =====
package woct_pkg;

   localparam int MAX_OPS_DEFAULT = 16;

   localparam int WORD_W  = 32;
   localparam int KIND_W  = 3;
   localparam int SLOT_W  = 4;
   localparam int COUNT_W = 5;
   localparam int ADDR_W  = 3;
   localparam int CSR_W   = 32;

   // Input item kinds.
   localparam logic ACTION_LOAD = 1'b0;
   localparam logic ACTION_DATA = 1'b1;

   // Operation codes; any other code leaves the word unchanged.
   localparam logic [KIND_W-1:0] KIND_ADD  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SUB  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_XOR  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ROTL = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ROTR = 3'd4;
   localparam logic [KIND_W-1:0] KIND_PASS = 3'd5;

   // Register index, taken from the word address.
   localparam logic REG_OP_COUNT = 1'b0;
   localparam logic [COUNT_W-1:0] OP_COUNT_RESET = 5'd1;

   typedef struct packed {
      logic                action;
      logic [SLOT_W-1:0]   op_slot;
      logic [KIND_W-1:0]   op_kind;
      logic [WORD_W-1:0]   op_value;
      logic [WORD_W-1:0]   data_word;
      logic                end_of_block;
   } woct_req_type;

   typedef struct packed {
      logic [WORD_W-1:0]   result_word;
      logic                end_of_block_out;
   } woct_rsp_type;

   // One word moving along the chain of cells.
   typedef struct packed {
      logic                valid;
      logic [WORD_W-1:0]   word;
      logic                eob;
   } woct_stage_type;

   // Table write broadcast to all cells.
   typedef struct packed {
      logic                en;
      logic [SLOT_W-1:0]   slot;
      logic [KIND_W-1:0]   kind;
      logic [WORD_W-1:0]   value;
   } woct_load_type;

   function automatic logic [WORD_W-1:0] apply_op(
      input logic [KIND_W-1:0] kind,
      input logic [WORD_W-1:0] operand,
      input logic [WORD_W-1:0] word
   );
      logic [2*WORD_W-1:0] dbl;
      logic [WORD_W-1:0]   res;
      dbl = '0;
      res = word;
      case (kind)
         KIND_ADD: begin
            res = word + operand;
         end
         KIND_SUB: begin
            res = word - operand;
         end
         KIND_XOR: begin
            res = word ^ operand;
         end
         KIND_ROTL: begin
            dbl = {word, word} << operand[4:0];
            res = dbl[2*WORD_W-1:WORD_W];
         end
         KIND_ROTR: begin
            dbl = {word, word} >> operand[4:0];
            res = dbl[WORD_W-1:0];
         end
         default: begin
            res = word;
         end
      endcase
      return res;
   endfunction

endpackage

// ===== src/word_op_chain_transform.sv =====
// Programmable word transform built as a chain of operation cells.
// Input channel (req_): load items write one table entry into the cell of
// that slot and give no result; data items enter the chain and give one
// result on the rsp_ channel, with the end-of-block mark carried along.
// Cell i holds table entry i and applies it when i is below op_count;
// higher cells pass the word through, so every data word takes the same
// path through all MAX_OPS cells.
// Each data word is registered in every cell in turn and then in the
// output register that drives rsp_valid; the first cell loads at the edge
// of the transfer. While the receiver keeps up, data items may follow each
// other in every cycle, so throughput is one word per cycle. A load item is
// held off while data words are still in the chain. When the receiver stalls
// with a result waiting, the whole chain freezes and req_stall goes high;
// nothing is dropped. op_count is written through the APB port at byte
// address 0; the user must write it only while the block is idle, which the
// block does not enforce. Reset empties the chain and sets op_count to 1;
// table entries are not cleared and must be loaded before use.
module word_op_chain_transform #(
   parameter int MAX_OPS = woct_pkg::MAX_OPS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  woct_pkg::woct_req_type         req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output woct_pkg::woct_rsp_type         rsp_payload,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [woct_pkg::ADDR_W-1:0]    paddr,
   input  logic [woct_pkg::CSR_W-1:0]     pwdata,
   output logic [woct_pkg::CSR_W-1:0]     prdata,
   output logic                           pready
);
   import woct_pkg::*;

   logic [COUNT_W-1:0] op_count_ff;
   logic               out_valid_ff;
   woct_rsp_type       out_payload_ff;
   woct_stage_type     stage [0:MAX_OPS];
   logic [MAX_OPS-1:0] busy_bits;
   woct_load_type      load;
   logic               advance;
   logic               in_flight;
   logic               req_fire;
   logic               csr_write;

   // Configuration register.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && (paddr[2] == REG_OP_COUNT);
   assign prdata    = (paddr[2] == REG_OP_COUNT) ? {{(CSR_W-COUNT_W){1'b0}}, op_count_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_count_ff <= OP_COUNT_RESET;
      end else if (csr_write) begin
         op_count_ff <= pwdata[COUNT_W-1:0];
      end
   end

   // The chain moves whenever the output register is free or being emptied.
   assign advance   = !out_valid_ff || !rsp_stall;
   assign in_flight = |busy_bits;
   assign req_stall = !advance || ((req_payload.action == ACTION_LOAD) && in_flight);
   assign req_fire  = req_valid && !req_stall;

   assign load.en    = req_fire && (req_payload.action == ACTION_LOAD);
   assign load.slot  = req_payload.op_slot;
   assign load.kind  = req_payload.op_kind;
   assign load.value = req_payload.op_value;

   assign stage[0].valid = req_fire && (req_payload.action == ACTION_DATA);
   assign stage[0].word  = req_payload.data_word;
   assign stage[0].eob   = req_payload.end_of_block;

   for (genvar i = 0; i < MAX_OPS; i++) begin : g_cell
      woct_cell #(
         .CELL_INDEX(i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .op_count(op_count_ff),
         .load    (load),
         .prev    (stage[i]),
         .next    (stage[i+1])
      );
      assign busy_bits[i] = stage[i+1].valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= stage[MAX_OPS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_payload_ff.result_word      <= stage[MAX_OPS].word;
         out_payload_ff.end_of_block_out <= stage[MAX_OPS].eob;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_payload_ff;

endmodule

// ===== src/woct_cell.sv =====
module woct_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic [woct_pkg::COUNT_W-1:0]      op_count,
   input  woct_pkg::woct_load_type           load,
   input  woct_pkg::woct_stage_type          prev,
   output woct_pkg::woct_stage_type          next
);
   import woct_pkg::*;

   localparam logic [6:0] CellIdx = 7'(CELL_INDEX);

   logic [KIND_W-1:0] kind_ff;
   logic [WORD_W-1:0] value_ff;
   logic              valid_ff;
   logic [WORD_W-1:0] word_ff;
   logic              eob_ff;
   logic [WORD_W-1:0] word_in;
   logic              active;
   logic              wr_hit;

   // This cell's entry is applied only when it lies below the operation count.
   assign active  = {2'b00, op_count} > CellIdx;
   assign wr_hit  = load.en && ({3'b000, load.slot} == CellIdx);
   assign word_in = active ? apply_op(kind_ff, value_ff, prev.word) : prev.word;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= prev.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         word_ff <= word_in;
         eob_ff  <= prev.eob;
      end
      if (wr_hit) begin
         kind_ff  <= load.kind;
         value_ff <= load.value;
      end
   end

   assign next.valid = valid_ff;
   assign next.word  = word_ff;
   assign next.eob   = eob_ff;

endmodule

// ===== tb/word_op_chain_transform_tb.sv =====
`timescale 1ns / 1ps

module word_op_chain_transform_tb;
   import woct_pkg::*;

   localparam int MAX_OPS      = MAX_OPS_DEFAULT;
   localparam int LATENCY      = MAX_OPS + 1;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int IDLE_PERCENT = 14;
   localparam int PHASE_ITEMS  = 166;
   localparam int PHASES       = 8;

   // Codes with no operation behind them; the word passes unchanged.
   localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
   localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

   typedef struct packed {
      woct_req_type item;
      logic         known;
      woct_rsp_type result;
   } directed_row_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   woct_req_type       req_payload;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   woct_rsp_type       rsp_payload;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [ADDR_W-1:0]  paddr;
   logic [CSR_W-1:0]   pwdata;
   logic [CSR_W-1:0]   prdata;
   logic               pready;

   // Shadow of the block: operation table and op_count.
   logic [KIND_W-1:0]  shadow_kind [MAX_OPS];
   logic [WORD_W-1:0]  shadow_operand [MAX_OPS];
   logic [MAX_OPS-1:0] slot_loaded;
   logic [COUNT_W-1:0] op_count_setting;

   woct_rsp_type       pending_words [$];
   woct_rsp_type       oldest_word;
   directed_row_type   directed_rows [$];
   logic [COUNT_W-1:0] phase_counts [PHASES] = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'd5,
                                                 5'd9, 5'd16};
   int                 failures = 0;
   int                 cycle_count = 0;
   bit                 no_idle = 1'b0;

   word_op_chain_transform #(
      .MAX_OPS(MAX_OPS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic int chain_length();
      return (op_count_setting > MAX_OPS) ? MAX_OPS : int'(op_count_setting);
   endfunction

   function automatic logic [WORD_W-1:0] transform_word(input logic [WORD_W-1:0] word);
      logic [WORD_W-1:0] w;
      logic [4:0]        n;
      int                i;
      w = word;
      for (i = 0; i < chain_length(); i++) begin
         n = shadow_operand[i][4:0];
         case (shadow_kind[i])
            KIND_ADD: begin
               w = w + shadow_operand[i];
            end
            KIND_SUB: begin
               w = w - shadow_operand[i];
            end
            KIND_XOR: begin
               w = w ^ shadow_operand[i];
            end
            KIND_ROTL: begin
               if (n != 5'd0) w = (w << n) | (w >> (WORD_W - n));
            end
            KIND_ROTR: begin
               if (n != 5'd0) w = (w >> n) | (w << (WORD_W - n));
            end
            default: begin
            end
         endcase
      end
      return w;
   endfunction

   function automatic directed_row_type row(input logic action, input logic [SLOT_W-1:0] slot,
                                            input logic [KIND_W-1:0] kind,
                                            input logic [WORD_W-1:0] operand,
                                            input logic [WORD_W-1:0] word, input logic eob,
                                            input logic known,
                                            input logic [WORD_W-1:0] result);
      directed_row_type r;
      r.item.action = action;
      r.item.op_slot = slot;
      r.item.op_kind = kind;
      r.item.op_value = operand;
      r.item.data_word = word;
      r.item.end_of_block = eob;
      r.known = known;
      r.result.result_word = result;
      r.result.end_of_block_out = eob;
      return r;
   endfunction

   function automatic void add_row(input directed_row_type r);
      directed_rows = {directed_rows, r};
   endfunction

   function automatic void queue_result(input woct_rsp_type r);
      pending_words = {pending_words, r};
   endfunction

   // Operands and data words lean toward the edges and toward shift counts.
   function automatic logic [WORD_W-1:0] random_word();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return 32'h8000_0000;
         3: return 32'h0000_0001;
         4: return $urandom_range(63);
         default: return $urandom();
      endcase
   endfunction

   // A data item that would run through a slot never loaded becomes a load of
   // the lowest such slot instead.
   function automatic woct_req_type random_item();
      woct_req_type it;
      int           missing;
      int           s;
      it.action = ($urandom_range(99) < 25) ? ACTION_LOAD : ACTION_DATA;
      it.op_slot = SLOT_W'($urandom_range(MAX_OPS - 1));
      it.op_kind = KIND_W'($urandom_range(7));
      it.op_value = random_word();
      it.data_word = random_word();
      it.end_of_block = 1'($urandom_range(1));
      missing = -1;
      for (s = chain_length() - 1; s >= 0; s--) begin
         if (!slot_loaded[s]) missing = s;
      end
      if (it.action == ACTION_DATA && missing >= 0) begin
         it.action = ACTION_LOAD;
         it.op_slot = SLOT_W'(missing);
      end
      return it;
   endfunction

   task automatic record_transfer(input woct_req_type item, input logic known,
                                  input woct_rsp_type result);
      woct_rsp_type word_out;
      if (item.action == ACTION_LOAD) begin
         if (item.op_slot < MAX_OPS) begin
            shadow_kind[item.op_slot] = item.op_kind;
            shadow_operand[item.op_slot] = item.op_value;
            slot_loaded[item.op_slot] = 1'b1;
         end
      end else if (known) begin
         queue_result(result);
      end else begin
         word_out.result_word = transform_word(item.data_word);
         word_out.end_of_block_out = item.end_of_block;
         queue_result(word_out);
      end
   endtask

   // Called right after a rising edge; returns at the edge of the transfer.
   task automatic send_item(input woct_req_type item, input logic known,
                            input woct_rsp_type result);
      while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      record_transfer(item, known, result);
   endtask

   task automatic drain_results(input int settle);
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_op_count(input logic [COUNT_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {REG_OP_COUNT, 2'b00};
      pwdata <= CSR_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      op_count_setting = value;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_words.size() == 0) begin
               failures++;
               $display("%0t: unexpected result, expected none, actual %h", $time,
                        rsp_payload);
            end else begin
               oldest_word = pending_words.pop_front();
               if (rsp_payload.result_word !== oldest_word.result_word) begin
                  failures++;
                  $display("%0t: result_word expected %h actual %h", $time,
                           oldest_word.result_word, rsp_payload.result_word);
               end
               if (rsp_payload.end_of_block_out !== oldest_word.end_of_block_out) begin
                  failures++;
                  $display("%0t: end_of_block_out expected %b actual %b", $time,
                           oldest_word.end_of_block_out, rsp_payload.end_of_block_out);
               end
            end
         end
         rsp_stall <= !no_idle && ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   initial begin
      int p;
      int n;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      slot_loaded = '0;
      op_count_setting = OP_COUNT_RESET;
      phase_counts[6] = COUNT_W'($urandom_range(2, 15));

      // With op_count at its reset value only slot 0 is in the chain.
      add_row(row(ACTION_LOAD, 0, KIND_ADD, 32'd1, 0, 0, 0, 0));
      add_row(row(ACTION_DATA, 0, 0, 0, 32'hFFFF_FFFF, 1, 1, 32'h0));
      add_row(row(ACTION_LOAD, 0, KIND_SUB, 32'd1, 0, 0, 0, 0));
      add_row(row(ACTION_DATA, 0, 0, 0, 32'h0, 0, 1, 32'hFFFF_FFFF));
      add_row(row(ACTION_LOAD, 0, KIND_XOR, 32'hFFFF_FFFF, 0, 0, 0, 0));
      add_row(row(ACTION_DATA, 0, 0, 0, 32'h1234_5678, 0, 1, 32'hEDCB_A987));
      add_row(row(ACTION_LOAD, 0, KIND_ROTL, 32'd1, 0, 0, 0, 0));
      add_row(row(ACTION_DATA, 0, 0, 0, 32'h8000_0000, 1, 1, 32'h0000_0001));
      add_row(row(ACTION_LOAD, 0, KIND_ROTR, 32'd33, 0, 0, 0, 0));
      add_row(row(ACTION_DATA, 0, 0, 0, 32'h0000_0001, 0, 1, 32'h8000_0000));
      add_row(row(ACTION_LOAD, 0, KIND_ROTL, 32'd32, 0, 0, 0, 0));
      add_row(row(ACTION_DATA, 0, 0, 0, 32'hA5A5_A5A5, 0, 1, 32'hA5A5_A5A5));
      add_row(row(ACTION_LOAD, 0, KIND_ROTR, 32'hFFFF_FFFF, 0, 0, 0, 0));
      add_row(row(ACTION_DATA, 0, 0, 0, 32'h0000_0001, 1, 1, 32'h0000_0002));
      // Data fields on a load and table fields on a data item are don't-cares.
      add_row(row(ACTION_LOAD, 0, KIND_PASS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 0));
      add_row(row(ACTION_DATA, 15, KIND_ROTL, 32'hFFFF_FFFF, 32'hDEAD_BEEF, 1, 1,
                  32'hDEAD_BEEF));
      add_row(row(ACTION_LOAD, 0, KIND_SPARE_HI, 32'd5, 0, 0, 0, 0));
      add_row(row(ACTION_DATA, 0, 0, 0, 32'h0, 0, 1, 32'h0));
      add_row(row(ACTION_LOAD, 15, KIND_SPARE_LO, 32'hFFFF_FFFF, 0, 0, 0, 0));
      add_row(row(ACTION_LOAD, 1, KIND_ADD, 32'd16, 0, 0, 0, 0));
      add_row(row(ACTION_LOAD, 0, KIND_SUB, 32'hFFFF_FFFF, 0, 0, 0, 0));
      add_row(row(ACTION_DATA, 0, 0, 0, 32'hFFFF_FFFF, 0, 1, 32'h0));
      add_row(row(ACTION_DATA, 0, 0, 0, 32'h7FFF_FFFF, 1, 1, 32'h8000_0000));
      add_row(row(ACTION_DATA, 0, 0, 0, 32'h0, 0, 0, 0));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].item, directed_rows[i].known, directed_rows[i].result);
      end

      for (p = 0; p < PHASES; p++) begin
         // Loads give no result and write the table directly, so none is ever in
         // the chain when the queue runs empty.
         drain_results(LATENCY + 4);
         write_op_count(phase_counts[p]);
         no_idle = (p == 3);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 1 && n == PHASE_ITEMS / 2) drain_results(0);
            send_item(random_item(), 1'b0, '0);
         end
      end
      no_idle = 1'b0;

      drain_results(LATENCY + 8);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/woct_pkg.sv
src/woct_cell.sv
src/word_op_chain_transform.sv
tb/word_op_chain_transform_tb.sv
